// ===== sv/assert_macros.svh =====
// Assertion macros shared by the convolution block's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define C2DV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition holds in the cycle after a trigger.
`define C2DV_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) trig |=> cond) else $error(msg);

`endif

// ===== sv/c2dv_pkg.sv =====
// Shared constants, types and codes for the convolution block.
package c2dv_pkg;

    localparam int MAX_WIDTH        = 256;
    localparam int MAX_HEIGHT       = 256;
    localparam int MAX_KERNEL       = 5;
    localparam int MAX_IN_CHANNELS  = 4;
    localparam int MAX_OUT_CHANNELS = 8;

    localparam int LINE_DEPTH   = MAX_KERNEL * MAX_WIDTH;
    localparam int WEIGHT_DEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL;

    localparam int LINE_AW   = $clog2(LINE_DEPTH);
    localparam int WEIGHT_AW = 10;
    localparam int ROW_W     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int KR_W      = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int CH_W      = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1;
    localparam int OC_W      = 3;

    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int ACC_W    = 40;
    localparam int WORD_W   = SAMPLE_W * MAX_IN_CHANNELS;

    localparam int IC_CFG_W = 3;
    localparam int OC_CFG_W = 4;
    localparam int K_CFG_W  = 3;
    localparam int DIM_W    = 9;
    localparam int CFG_W    = 9;
    localparam int CFG_IW   = 3;

    typedef enum logic [CFG_IW-1:0] {
        REG_IN_CHANNELS   = 3'd0,
        REG_OUT_CHANNELS  = 3'd1,
        REG_KERNEL_HEIGHT = 3'd2,
        REG_KERNEL_WIDTH  = 3'd3,
        REG_IMAGE_HEIGHT  = 3'd4,
        REG_IMAGE_WIDTH   = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_LOAD,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic                 wt_write;
        logic                 pix_write;
        logic [KR_W-1:0]      pix_row;
        logic [COL_W-1:0]     pix_col;
        logic                 acc_clr;
        logic                 issue;
        logic [CH_W-1:0]      rd_ch;
        logic [KR_W-1:0]      rd_row;
        logic [COL_W-1:0]     rd_col;
        logic [WEIGHT_AW-1:0] waddr;
        logic                 load_out;
        logic [OC_W-1:0]      oc;
        logic [ROW_W-1:0]     top;
        logic [COL_W-1:0]     left;
        logic                 last;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic out_full;
    } status_t;

endpackage

// ===== sv/c2dv_dp.sv =====
// Datapath: line and weight stores, multiply-accumulate pipe and result register.
`include "assert_macros.svh"
module c2dv_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  c2dv_pkg::cmd_t                        cmd,
    output c2dv_pkg::status_t                     status,
    input  logic [c2dv_pkg::WEIGHT_AW-1:0]        weight_index,
    input  logic signed [c2dv_pkg::SAMPLE_W-1:0]  weight_value,
    input  logic signed [c2dv_pkg::SAMPLE_W-1:0]  pixel_c0,
    input  logic signed [c2dv_pkg::SAMPLE_W-1:0]  pixel_c1,
    input  logic signed [c2dv_pkg::SAMPLE_W-1:0]  pixel_c2,
    input  logic signed [c2dv_pkg::SAMPLE_W-1:0]  pixel_c3,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [c2dv_pkg::OC_W-1:0]             out_channel,
    output logic [c2dv_pkg::ROW_W-1:0]            out_row,
    output logic [c2dv_pkg::COL_W-1:0]            out_col,
    output logic signed [c2dv_pkg::ACC_W-1:0]     value,
    output logic                                  last
);
    import c2dv_pkg::*;

    logic [WORD_W-1:0]          line_mem [LINE_DEPTH];
    logic [SAMPLE_W-1:0]        wt_mem [WEIGHT_DEPTH];

    logic [LINE_AW-1:0]         wr_addr;
    logic [LINE_AW-1:0]         rd_addr;
    logic [WORD_W-1:0]          rd_word_reg;
    logic [SAMPLE_W-1:0]        rd_wt_reg;
    logic                       v1_reg;
    logic [CH_W-1:0]            ch1_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic                       v2_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       out_valid_reg;
    logic [OC_W-1:0]            oc_reg;
    logic [ROW_W-1:0]           row_reg;
    logic [COL_W-1:0]           col_reg;
    logic signed [ACC_W-1:0]    val_reg;
    logic                       last_reg;

    assign wr_addr = LINE_AW'(cmd.pix_row) * LINE_AW'(MAX_WIDTH) + LINE_AW'(cmd.pix_col);
    assign rd_addr = LINE_AW'(cmd.rd_row) * LINE_AW'(MAX_WIDTH) + LINE_AW'(cmd.rd_col);

    always_ff @(posedge clk)
    begin
        if (cmd.pix_write)
        begin
            line_mem[wr_addr] <= {pixel_c3, pixel_c2, pixel_c1, pixel_c0};
        end
        if (cmd.wt_write && (32'(weight_index) < WEIGHT_DEPTH))
        begin
            wt_mem[weight_index] <= weight_value;
        end
        rd_word_reg <= line_mem[rd_addr];
        rd_wt_reg   <= wt_mem[cmd.waddr];
    end

    assign sample = rd_word_reg[SAMPLE_W*ch1_reg +: SAMPLE_W];

    always_ff @(posedge clk)
    begin
        ch1_reg  <= cmd.rd_ch;
        prod_reg <= sample * $signed(rd_wt_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // The result register holds each loaded result until it is taken with out_stall low.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            oc_reg   <= cmd.oc;
            row_reg  <= cmd.top;
            col_reg  <= cmd.left;
            val_reg  <= acc_reg;
            last_reg <= cmd.last;
        end
    end

    assign status.busy     = v1_reg | v2_reg;
    assign status.out_full = out_valid_reg;

    assign out_valid   = out_valid_reg;
    assign out_channel = oc_reg;
    assign out_row     = row_reg;
    assign out_col     = col_reg;
    assign value       = val_reg;
    assign last        = last_reg;

    `C2DV_ASSERT(a_load_empty, cmd.load_out |-> !(v1_reg || v2_reg || out_valid_reg), "result loaded while pipe or output busy")
    `C2DV_ASSERT(a_clr_idle, cmd.acc_clr |-> !(v1_reg || v2_reg), "accumulator cleared with products in flight")

endmodule

// ===== sv/c2dv_ctrl.sv =====
// Controller: configuration registers, frame counters and the window sequencer.
`include "assert_macros.svh"
module c2dv_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [c2dv_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [c2dv_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          func,
    input  c2dv_pkg::status_t             status,
    output c2dv_pkg::cmd_t                cmd
);
    import c2dv_pkg::*;

    state_t               state_reg, state_next;
    logic [IC_CFG_W-1:0]  ic_reg;
    logic [OC_CFG_W-1:0]  ocn_reg;
    logic [K_CFG_W-1:0]   kh_reg;
    logic [K_CFG_W-1:0]   kw_reg;
    logic [DIM_W-1:0]     ih_reg;
    logic [DIM_W-1:0]     iw_reg;

    logic [ROW_W-1:0]     row_reg, row_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [KR_W-1:0]      rmod_reg, rmod_next;
    logic [ROW_W-1:0]     top_reg, top_next;
    logic [COL_W-1:0]     left_reg, left_next;
    logic [KR_W-1:0]      tmod_reg, tmod_next;
    logic [OC_W-1:0]      oc_reg, oc_next;
    logic [CH_W-1:0]      ch_reg, ch_next;
    logic [K_CFG_W-1:0]   p_reg, p_next;
    logic [K_CFG_W-1:0]   q_reg, q_next;
    logic [KR_W-1:0]      lrow_reg, lrow_next;
    logic [WEIGHT_AW-1:0] waddr_reg, waddr_next;

    logic                 accept;
    logic                 window;
    logic                 oc_last;
    logic [KR_W:0]        tmod_sum;
    logic [IC_CFG_W-1:0]  ic_w;
    logic [OC_CFG_W-1:0]  oc_w;
    logic [K_CFG_W-1:0]   k_w;
    logic [DIM_W-1:0]     ih_w;
    logic [DIM_W-1:0]     iw_w;

    // Written values are clamped into each register's legal range.
    always_comb
    begin
        ic_w = cfg_data[IC_CFG_W-1:0];
        if (ic_w == '0) ic_w = IC_CFG_W'(1);
        else if (32'(ic_w) > MAX_IN_CHANNELS) ic_w = IC_CFG_W'(MAX_IN_CHANNELS);
        oc_w = cfg_data[OC_CFG_W-1:0];
        if (oc_w == '0) oc_w = OC_CFG_W'(1);
        else if (32'(oc_w) > MAX_OUT_CHANNELS) oc_w = OC_CFG_W'(MAX_OUT_CHANNELS);
        k_w = cfg_data[K_CFG_W-1:0];
        if (k_w == '0) k_w = K_CFG_W'(1);
        else if (32'(k_w) > MAX_KERNEL) k_w = K_CFG_W'(MAX_KERNEL);
        ih_w = cfg_data[DIM_W-1:0];
        if (ih_w == '0) ih_w = DIM_W'(1);
        else if (32'(ih_w) > MAX_HEIGHT) ih_w = DIM_W'(MAX_HEIGHT);
        iw_w = cfg_data[DIM_W-1:0];
        if (iw_w == '0) iw_w = DIM_W'(1);
        else if (32'(iw_w) > MAX_WIDTH) iw_w = DIM_W'(MAX_WIDTH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ic_reg  <= IC_CFG_W'(1);
            ocn_reg <= OC_CFG_W'(1);
            kh_reg  <= K_CFG_W'(3);
            kw_reg  <= K_CFG_W'(3);
            ih_reg  <= DIM_W'(MAX_HEIGHT);
            iw_reg  <= DIM_W'(MAX_WIDTH);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_IN_CHANNELS:   ic_reg  <= ic_w;
                REG_OUT_CHANNELS:  ocn_reg <= oc_w;
                REG_KERNEL_HEIGHT: kh_reg  <= k_w;
                REG_KERNEL_WIDTH:  kw_reg  <= k_w;
                REG_IMAGE_HEIGHT:  ih_reg  <= ih_w;
                REG_IMAGE_WIDTH:   iw_reg  <= iw_w;
                default:           ;
            endcase
        end
    end

    assign accept  = in_valid && (state_reg == ST_IDLE);
    assign window  = ((DIM_W'(row_reg) + DIM_W'(1)) >= DIM_W'(kh_reg))
                  && ((DIM_W'(col_reg) + DIM_W'(1)) >= DIM_W'(kw_reg));
    assign oc_last = (OC_CFG_W'(oc_reg) + OC_CFG_W'(1)) == ocn_reg;
    // Ring row of the window's top line: (rmod + 1 - kernel_height) mod MAX_KERNEL.
    assign tmod_sum = (KR_W+1)'(rmod_reg) + (KR_W+1)'(1)
                    + (KR_W+1)'(MAX_KERNEL) - (KR_W+1)'(kh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            rmod_reg  <= '0;
            top_reg   <= '0;
            left_reg  <= '0;
            tmod_reg  <= '0;
            oc_reg    <= '0;
            ch_reg    <= '0;
            p_reg     <= '0;
            q_reg     <= '0;
            lrow_reg  <= '0;
            waddr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            rmod_reg  <= rmod_next;
            top_reg   <= top_next;
            left_reg  <= left_next;
            tmod_reg  <= tmod_next;
            oc_reg    <= oc_next;
            ch_reg    <= ch_next;
            p_reg     <= p_next;
            q_reg     <= q_next;
            lrow_reg  <= lrow_next;
            waddr_reg <= waddr_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        rmod_next  = rmod_reg;
        top_next   = top_reg;
        left_next  = left_reg;
        tmod_next  = tmod_reg;
        oc_next    = oc_reg;
        ch_next    = ch_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        lrow_next  = lrow_reg;
        waddr_next = waddr_reg;

        cmd           = '0;
        cmd.pix_row   = rmod_reg;
        cmd.pix_col   = col_reg;
        cmd.rd_ch     = ch_reg;
        cmd.rd_row    = lrow_reg;
        cmd.rd_col    = left_reg + COL_W'(q_reg);
        cmd.waddr     = waddr_reg;
        cmd.oc        = oc_reg;
        cmd.top       = top_reg;
        cmd.left      = left_reg;
        cmd.last      = oc_last;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !func)
                begin
                    cmd.wt_write = 1'b1;
                end
                else if (accept)
                begin
                    cmd.pix_write = 1'b1;
                    if (window)
                    begin
                        top_next   = ROW_W'(DIM_W'(row_reg) + DIM_W'(1) - DIM_W'(kh_reg));
                        left_next  = COL_W'(DIM_W'(col_reg) + DIM_W'(1) - DIM_W'(kw_reg));
                        tmod_next  = (tmod_sum >= (KR_W+1)'(MAX_KERNEL))
                                   ? KR_W'(tmod_sum - (KR_W+1)'(MAX_KERNEL))
                                   : KR_W'(tmod_sum);
                        lrow_next  = tmod_next;
                        oc_next    = '0;
                        ch_next    = '0;
                        p_next     = '0;
                        q_next     = '0;
                        waddr_next = '0;
                        cmd.acc_clr = 1'b1;
                        state_next = ST_MAC;
                    end
                    if ((DIM_W'(col_reg) + DIM_W'(1)) >= iw_reg)
                    begin
                        col_next = '0;
                        if ((DIM_W'(row_reg) + DIM_W'(1)) >= ih_reg)
                        begin
                            row_next  = '0;
                            rmod_next = '0;
                        end
                        else
                        begin
                            row_next  = row_reg + ROW_W'(1);
                            rmod_next = (32'(rmod_reg) == MAX_KERNEL - 1)
                                      ? '0 : rmod_reg + KR_W'(1);
                        end
                    end
                    else
                    begin
                        col_next = col_reg + COL_W'(1);
                    end
                end
                // Only a write to an existing register restarts the frame.
                if (cfg_we && (cfg_index <= CFG_IW'(REG_IMAGE_WIDTH)))
                begin
                    row_next  = '0;
                    col_next  = '0;
                    rmod_next = '0;
                end
            end
            ST_MAC:
            begin
                // One product issued per cycle, in the weight store's own order.
                cmd.issue  = 1'b1;
                waddr_next = waddr_reg + WEIGHT_AW'(1);
                if ((q_reg + K_CFG_W'(1)) == kw_reg)
                begin
                    q_next = '0;
                    lrow_next = (32'(lrow_reg) == MAX_KERNEL - 1) ? '0 : lrow_reg + KR_W'(1);
                    if ((p_reg + K_CFG_W'(1)) == kh_reg)
                    begin
                        p_next    = '0;
                        lrow_next = tmod_reg;
                        ch_next   = ch_reg + CH_W'(1);
                        if ((IC_CFG_W'(ch_reg) + IC_CFG_W'(1)) == ic_reg)
                        begin
                            ch_next    = '0;
                            state_next = ST_DRAIN;
                        end
                    end
                    else
                    begin
                        p_next = p_reg + K_CFG_W'(1);
                    end
                end
                else
                begin
                    q_next = q_reg + K_CFG_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!status.busy)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load_out = 1'b1;
                state_next   = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (!status.out_full)
                begin
                    if (oc_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        oc_next     = oc_reg + OC_W'(1);
                        cmd.acc_clr = 1'b1;
                        state_next  = ST_MAC;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

    `C2DV_ASSERT(a_oc_range, (state_reg == ST_MAC) |-> ((OC_CFG_W'(oc_reg) < ocn_reg)), "output channel beyond configured count")
    `C2DV_ASSERT_NEXT(a_load_hold, (state_reg == ST_LOAD), (state_reg == ST_HOLD) && status.out_full, "result not held after load")
    `C2DV_ASSERT_NEXT(a_last_idle, (state_reg == ST_HOLD) && !status.out_full && oc_last, (state_reg == ST_IDLE), "sequencer did not return to idle after last result")

endmodule

// ===== sv/conv2d_valid_multichannel.sv =====
// Top level of the streaming multichannel valid convolution.
//   Channel  Direction  Handshake          Payload
//   in       input      in_valid/in_stall  func, weight_index, weight_value, pixel_c0..c3
//   out      output     out_valid/out_stall out_channel, out_row, out_col, value, last
//   cfg      input      cfg_we             cfg_index, cfg_data
// A weight write or a pixel that completes no window leaves in_stall low.
// A pixel that completes a window raises in_stall while the single multiply-accumulate
// unit works through each output in turn: it issues the products, empties the pipe,
// loads the result register and waits for the output handshake.
// Each result waits in the output register; out_stall holds the sequencer there.
// Reset clears the counters and sets the configuration to its defaults; the stores need no clearing pass.
module conv2d_valid_multichannel (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [c2dv_pkg::CFG_IW-1:0]           cfg_index,
    input  logic [c2dv_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  func,
    input  logic [c2dv_pkg::WEIGHT_AW-1:0]        weight_index,
    input  logic signed [c2dv_pkg::SAMPLE_W-1:0]  weight_value,
    input  logic signed [c2dv_pkg::SAMPLE_W-1:0]  pixel_c0,
    input  logic signed [c2dv_pkg::SAMPLE_W-1:0]  pixel_c1,
    input  logic signed [c2dv_pkg::SAMPLE_W-1:0]  pixel_c2,
    input  logic signed [c2dv_pkg::SAMPLE_W-1:0]  pixel_c3,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [c2dv_pkg::OC_W-1:0]             out_channel,
    output logic [c2dv_pkg::ROW_W-1:0]            out_row,
    output logic [c2dv_pkg::COL_W-1:0]            out_col,
    output logic signed [c2dv_pkg::ACC_W-1:0]     value,
    output logic                                  last
);
    import c2dv_pkg::*;

    cmd_t    cmd;
    status_t status;

    c2dv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .status    (status),
        .cmd       (cmd)
    );

    c2dv_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .weight_index (weight_index),
        .weight_value (weight_value),
        .pixel_c0     (pixel_c0),
        .pixel_c1     (pixel_c1),
        .pixel_c2     (pixel_c2),
        .pixel_c3     (pixel_c3),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_channel  (out_channel),
        .out_row      (out_row),
        .out_col      (out_col),
        .value        (value),
        .last         (last)
    );

endmodule
